// ===== design/tmcq_pkg.sv =====
// Shared types, constants and helpers of the tile majority color quantizer.
package tmcq_pkg;

	localparam int MaxTilePixels = 4096;
	localparam int CountWidth    = $clog2(MaxTilePixels + 1);
	localparam int NumLevels     = 3;
	localparam int ChanWidth     = 8;

	localparam logic [ChanWidth-1:0] LowThresholdReset  = 8'd85;
	localparam logic [ChanWidth-1:0] HighThresholdReset = 8'd170;

	// Register indexes on the configuration port.
	localparam logic RegLowThreshold  = 1'b0;
	localparam logic RegHighThreshold = 1'b1;

	typedef enum logic [1:0] {
		LVL_DARK   = 2'd0,
		LVL_MID    = 2'd1,
		LVL_BRIGHT = 2'd2
	} level_t;

	typedef logic [ChanWidth-1:0]  chan_t;
	typedef logic [CountWidth-1:0] count_t;
	typedef count_t [NumLevels-1:0] level_counts_t;

	typedef struct packed {
		logic count_en;
		logic tile_end;
	} lane_ctrl_t;

	function automatic chan_t level_value(level_t lvl);
		chan_t v;
		unique case (lvl)
			LVL_DARK:   v = 8'd0;
			LVL_MID:    v = 8'd127;
			LVL_BRIGHT: v = 8'd255;
			default:    v = 8'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== design/tile_majority_color_quantizer_top.sv =====
// Top level of the tile majority color quantizer with its configuration registers.
//
// Usage: pixels of one tile arrive on the pixel channel (pix_valid, pix_ready,
// red, green, blue, last_in_tile), one pixel per transaction, and the flag
// last_in_tile marks the final pixel of the tile. For every tile the block
// returns one transaction on the tile channel (tile_valid, tile_ready,
// out_red, out_green, out_blue) that carries the majority level of each
// channel as 0, 127 or 255.
// Throughput is one pixel per cycle unless back-pressure stops it: three channel
// lanes classify and count in the cycle the pixel is taken, so even one-pixel
// tiles stream at full rate. The final counts of a tile are registered in the
// capture stage and its color then in the output register of the merge stage.
// When the receiver stalls, the color waits in the output register and the
// next tile's final counts wait in the capture stage. Once both are full,
// pix_ready drops and no pixel is taken until the receiver accepts the color.
// Reset clears all counters and sets the thresholds to 85 and 170. The
// thresholds are written over the APB port, at byte address 0 for the low
// threshold and 4 for the high one, and should change only while idle.
module tile_majority_color_quantizer_top import tmcq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// Pixel channel.
	input  logic        pix_valid,
	output logic        pix_ready,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	input  logic        last_in_tile,
	// Tile color channel.
	output logic        tile_valid,
	input  logic        tile_ready,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	chan_t         low_threshold_q;
	chan_t         high_threshold_q;
	logic          pix_take;
	logic          merge_advance;
	lane_ctrl_t    lane_ctrl;
	level_counts_t red_next;
	level_counts_t green_next;
	level_counts_t blue_next;
	logic          valid_s1;
	level_counts_t red_counts_s1;
	level_counts_t green_counts_s1;
	level_counts_t blue_counts_s1;
	logic          cfg_write;

	// Configuration registers. Only bit 2 of the address selects the register.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_threshold_q  <= LowThresholdReset;
			high_threshold_q <= HighThresholdReset;
		end else if (cfg_write) begin
			unique case (paddr[2])
				RegLowThreshold:  low_threshold_q  <= pwdata[ChanWidth-1:0];
				RegHighThreshold: high_threshold_q <= pwdata[ChanWidth-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			RegLowThreshold:  prdata = {{(32 - ChanWidth){1'b0}}, low_threshold_q};
			RegHighThreshold: prdata = {{(32 - ChanWidth){1'b0}}, high_threshold_q};
			default:          prdata = '0;
		endcase
	end

	// A pixel is taken whenever the capture stage is free or drains this cycle.
	assign pix_ready = !valid_s1 || merge_advance;
	assign pix_take  = pix_valid && pix_ready;

	assign lane_ctrl.count_en = pix_take;
	assign lane_ctrl.tile_end = last_in_tile;

	tmcq_lane u_lane_red (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (lane_ctrl),
		.value          (red),
		.low_threshold  (low_threshold_q),
		.high_threshold (high_threshold_q),
		.counts_next    (red_next)
	);

	tmcq_lane u_lane_green (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (lane_ctrl),
		.value          (green),
		.low_threshold  (low_threshold_q),
		.high_threshold (high_threshold_q),
		.counts_next    (green_next)
	);

	tmcq_lane u_lane_blue (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (lane_ctrl),
		.value          (blue),
		.low_threshold  (low_threshold_q),
		.high_threshold (high_threshold_q),
		.counts_next    (blue_next)
	);

	// Capture stage: the final counts of a finished tile, including its last pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_take && last_in_tile) begin
			valid_s1 <= 1'b1;
		end else if (merge_advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_take && last_in_tile) begin
			red_counts_s1   <= red_next;
			green_counts_s1 <= green_next;
			blue_counts_s1  <= blue_next;
		end
	end

	tmcq_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.counts_valid (valid_s1),
		.red_counts   (red_counts_s1),
		.green_counts (green_counts_s1),
		.blue_counts  (blue_counts_s1),
		.advance      (merge_advance),
		.tile_valid   (tile_valid),
		.tile_ready   (tile_ready),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue)
	);

	a_tile_end_captured: assert property (@(posedge clk) disable iff (!arst_n)
		pix_take && last_in_tile |=> valid_s1)
		else $error("finished tile was not captured");

	a_capture_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !merge_advance |=> valid_s1 && $stable(red_counts_s1) &&
			$stable(green_counts_s1) && $stable(blue_counts_s1))
		else $error("captured counts lost while the output stalled");

	a_capture_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && merge_advance |=> tile_valid)
		else $error("captured tile did not reach the output register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !merge_advance |-> !pix_ready)
		else $error("pixel taken while a stalled capture stage is full");

endmodule

// ===== design/tmcq_lane.sv =====
// One channel lane: sorts a channel value into a level and keeps the level counters.
module tmcq_lane import tmcq_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  lane_ctrl_t    ctrl,
	input  chan_t         value,
	input  chan_t         low_threshold,
	input  chan_t         high_threshold,
	output level_counts_t counts_next
);

	level_counts_t counts_q;
	level_t        level;

	always_comb begin
		priority if (value < low_threshold) begin
			level = LVL_DARK;
		end else if (value < high_threshold) begin
			level = LVL_MID;
		end else begin
			level = LVL_BRIGHT;
		end
	end

	// Counts including the current pixel; each counter saturates at the tile bound.
	always_comb begin
		for (int lv = 0; lv < NumLevels; lv++) begin
			if ((level == level_t'(lv)) && (counts_q[lv] < CountWidth'(MaxTilePixels))) begin
				counts_next[lv] = counts_q[lv] + 1'b1;
			end else begin
				counts_next[lv] = counts_q[lv];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counts_q <= '0;
		end else if (ctrl.count_en) begin
			counts_q <= ctrl.tile_end ? '0 : counts_next;
		end
	end

	a_clear_after_tile: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.count_en && ctrl.tile_end |=> counts_q == '0)
		else $error("lane counters not cleared after tile end");

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.count_en |=> $stable(counts_q))
		else $error("lane counters changed without a pixel");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.count_en && !ctrl.tile_end |=>
			counts_q[LVL_DARK] <= CountWidth'(MaxTilePixels) &&
			counts_q[LVL_MID] <= CountWidth'(MaxTilePixels) &&
			counts_q[LVL_BRIGHT] <= CountWidth'(MaxTilePixels))
		else $error("lane counter passed the saturation bound");

endmodule

// ===== design/tmcq_merge.sv =====
// Merge stage: picks the majority level of each lane and holds the tile color.
module tmcq_merge import tmcq_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          counts_valid,
	input  level_counts_t red_counts,
	input  level_counts_t green_counts,
	input  level_counts_t blue_counts,
	output logic          advance,
	output logic          tile_valid,
	input  logic          tile_ready,
	output chan_t         out_red,
	output chan_t         out_green,
	output chan_t         out_blue
);

	logic  tile_valid_q;
	chan_t red_q;
	chan_t green_q;
	chan_t blue_q;

	// Strictly greater wins, so a tie keeps the lower level and an empty tile gives dark.
	function automatic level_t pick_level(level_counts_t c);
		count_t best;
		level_t pick;
		best = c[LVL_DARK];
		pick = LVL_DARK;
		if (c[LVL_MID] > best) begin
			best = c[LVL_MID];
			pick = LVL_MID;
		end
		if (c[LVL_BRIGHT] > best) begin
			pick = LVL_BRIGHT;
		end
		return pick;
	endfunction

	assign advance = !tile_valid_q || tile_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_valid_q <= 1'b0;
		end else if (advance) begin
			tile_valid_q <= counts_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && counts_valid) begin
			red_q   <= level_value(pick_level(red_counts));
			green_q <= level_value(pick_level(green_counts));
			blue_q  <= level_value(pick_level(blue_counts));
		end
	end

	assign tile_valid = tile_valid_q;
	assign out_red    = red_q;
	assign out_green  = green_q;
	assign out_blue   = blue_q;

endmodule

// ===== dv/tile_majority_color_quantizer_top_tb.sv =====
// Self-checking testbench for the tile majority color quantizer top level.
module tile_majority_color_quantizer_top_tb import tmcq_pkg::*; ();

	// Cycles without any accepted transaction before the run is declared hung.
	// The longest legal quiet stretch is the forced receiver hold-off or a long
	// random gap, so this leaves a wide margin.
	localparam int StallLimit   = 2000;
	// Cycles to let pass once the last color has arrived, enough to cover any
	// pixel still in flight through the capture and merge stages.
	localparam int SettleCycles = 6;
	localparam int RandomPixelsPerSetting = 200;
	localparam int NumSettings  = 8;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} tile_color_t;

	logic        clk;
	logic        arst_n;
	logic        pix_valid;
	logic        pix_ready;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        last_in_tile;
	logic        tile_valid;
	logic        tile_ready;
	logic [7:0]  out_red;
	logic [7:0]  out_green;
	logic [7:0]  out_blue;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Shadow of the block: thresholds and the per channel, per level pixel tally.
	chan_t  low_thr;
	chan_t  high_thr;
	count_t tally [3][NumLevels];

	// Tile colors predicted but not yet seen on the tile channel, oldest first.
	tile_color_t pending_colors [$];
	tile_color_t head_color;

	// Idling knobs: chance in percent that a transaction is preceded by a gap
	// (sender) or that the receiver starts a stall, and a forced long hold-off.
	int idle_pct;
	int stall_pct;
	int hold_len;
	int hold_left;
	int stall_left;

	int fail_count;
	int quiet_cycles;
	int pixels_sent;
	int tiles_sent;
	int tiles_checked;
	int threshold_writes;

	tile_majority_color_quantizer_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix_valid    (pix_valid),
		.pix_ready    (pix_ready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.last_in_tile (last_in_tile),
		.tile_valid   (tile_valid),
		.tile_ready   (tile_ready),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// A channel value is dark below the low threshold, middle below the high
	// threshold, and bright otherwise. With the thresholds out of order the
	// middle level simply never matches.
	function automatic level_t classify_level(chan_t v);
		if (v < low_thr) return LVL_DARK;
		if (v < high_thr) return LVL_MID;
		return LVL_BRIGHT;
	endfunction

	// The most frequent level of one channel wins; on a tie the lower level
	// keeps the lead because only a strictly larger count replaces it. A
	// channel with no counts at all stays at dark.
	function automatic chan_t majority_value(int ch);
		count_t best;
		level_t pick;
		best = '0;
		pick = LVL_DARK;
		for (int lv = 0; lv < NumLevels; lv++) begin
			if (tally[ch][lv] > best) begin
				best = tally[ch][lv];
				pick = level_t'(lv);
			end
		end
		case (pick)
			LVL_DARK: return 8'd0;
			LVL_MID:  return 8'd127;
			default:  return 8'd255;
		endcase
	endfunction

	// Counts one accepted pixel and, on a tile end, queues the tile color and
	// clears the tally. Each counter saturates at the tile size bound.
	function automatic void account_pixel(chan_t r, chan_t g, chan_t b, logic last);
		chan_t       px [3];
		level_t      lvl;
		tile_color_t color;
		px = '{r, g, b};
		for (int ch = 0; ch < 3; ch++) begin
			lvl = classify_level(px[ch]);
			if (tally[ch][lvl] < MaxTilePixels) tally[ch][lvl]++;
		end
		pixels_sent++;
		if (last) begin
			color.red   = majority_value(0);
			color.green = majority_value(1);
			color.blue  = majority_value(2);
			pending_colors.push_back(color);
			tiles_sent++;
			for (int ch = 0; ch < 3; ch++)
				for (int lv = 0; lv < NumLevels; lv++)
					tally[ch][lv] = '0;
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Mostly short gaps and stalls, with the odd long one.
	function automatic int gap_length();
		if ($urandom_range(9) == 0) return $urandom_range(40, 15);
		return $urandom_range(3, 1);
	endfunction

	// A random value that falls in the given level under the current
	// thresholds; when that level is empty any value will do.
	function automatic chan_t value_in_level(level_t lvl);
		int lo;
		int hi;
		case (lvl)
			LVL_DARK: begin
				lo = 0;
				hi = int'(low_thr) - 1;
			end
			LVL_MID: begin
				lo = int'(low_thr);
				hi = int'(high_thr) - 1;
			end
			default: begin
				lo = int'(high_thr);
				hi = 255;
			end
		endcase
		if (hi < lo) return chan_t'($urandom_range(255));
		return chan_t'($urandom_range(hi, lo));
	endfunction

	// Pixel content that mostly follows the tile's favored level but also hits
	// arbitrary values and the values at and just below either threshold.
	function automatic chan_t random_channel(level_t favored);
		int roll;
		roll = $urandom_range(9);
		if (roll < 6) return value_in_level(favored);
		if (roll < 8) return chan_t'($urandom_range(255));
		case ($urandom_range(3))
			0:       return low_thr;
			1:       return low_thr - 8'd1;
			2:       return high_thr;
			default: return high_thr - 8'd1;
		endcase
	endfunction

	// Offers one pixel, possibly after a gap, and holds it until the block
	// takes it. Valid stays high into the next call when no gap is drawn.
	task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b,
			input logic last);
		int gap;
		gap = ($urandom_range(99) < idle_pct) ? gap_length() : 0;
		@(negedge clk);
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_valid    <= 1'b1;
		red          <= r;
		green        <= g;
		blue         <= b;
		last_in_tile <= last;
		@(posedge clk);
		while (!pix_ready) @(posedge clk);
		account_pixel(r, g, b, last);
	endtask

	task automatic send_tile(input int size, input level_t fav_r, input level_t fav_g,
			input level_t fav_b);
		for (int i = 0; i < size; i++)
			send_pixel(random_channel(fav_r), random_channel(fav_g),
				random_channel(fav_b), i == size - 1);
	endtask

	// Stops offering pixels and waits until every predicted color has come
	// back, then lets the pipeline settle.
	task automatic wait_for_idle();
		@(negedge clk);
		pix_valid <= 1'b0;
		while (pending_colors.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// APB read of one threshold register, compared with the expected value.
	task automatic check_register(input logic idx, input chan_t want);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== {24'd0, want}) begin
			$error("prdata mismatch at register %0d: expected %0d, actual %0d",
				idx, want, prdata);
			fail_count++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// APB write of one threshold register followed by a read back. Only called
	// while the block is idle and at a tile boundary.
	task automatic write_threshold(input logic idx, input chan_t value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {24'd0, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (idx == RegLowThreshold) low_thr = value;
		else high_thr = value;
		threshold_writes++;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		check_register(idx, value);
	endtask

	task automatic set_thresholds(input chan_t lo, input chan_t hi);
		wait_for_idle();
		write_threshold(RegLowThreshold, lo);
		write_threshold(RegHighThreshold, hi);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_register_reset();
		check_register(RegLowThreshold, LowThresholdReset);
		check_register(RegHighThreshold, HighThresholdReset);
	endtask

	// One-pixel tiles at and next to each threshold and at the range ends,
	// under the reset thresholds.
	task automatic test_level_boundaries();
		send_pixel(8'd0,   8'd84,  8'd85,  1'b1);
		send_pixel(8'd169, 8'd170, 8'd255, 1'b1);
		send_pixel(8'd85,  8'd169, 8'd84,  1'b1);
		send_pixel(8'd255, 8'd0,   8'd170, 1'b1);
		send_pixel(8'd127, 8'd128, 8'd1,   1'b1);
		send_pixel(8'd254, 8'd86,  8'd171, 1'b1);
	endtask

	// Two-way ties, a three-way tie and a clear majority in one tile.
	task automatic test_tie_breaking();
		send_pixel(8'd0,   8'd255, 8'd100, 1'b0);
		send_pixel(8'd255, 8'd100, 8'd0,   1'b1);
		send_pixel(8'd0,   8'd100, 8'd200, 1'b0);
		send_pixel(8'd100, 8'd200, 8'd0,   1'b0);
		send_pixel(8'd200, 8'd0,   8'd100, 1'b1);
		send_pixel(8'd255, 8'd255, 8'd0,   1'b0);
		send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
		send_pixel(8'd0,   8'd100, 8'd100, 1'b1);
	endtask

	// Low threshold above the high one: the middle level can never be picked.
	task automatic test_inverted_thresholds();
		set_thresholds(8'd200, 8'd100);
		send_pixel(8'd50,  8'd150, 8'd250, 1'b1);
		send_pixel(8'd99,  8'd100, 8'd199, 1'b0);
		send_pixel(8'd200, 8'd201, 8'd255, 1'b1);
		set_thresholds(LowThresholdReset, HighThresholdReset);
	endtask

	// The receiver holds off for a long stretch while one- and two-pixel tiles arrive
	// back to back, so the output and capture stages fill and the pixel
	// channel has to stall. Afterwards the sender pauses until all is drained.
	task automatic test_output_backpressure();
		idle_pct = 0;
		hold_len = 80;
		for (int i = 0; i < 30; i++)
			send_tile($urandom_range(2, 1), level_t'($urandom_range(2)),
				level_t'($urandom_range(2)), level_t'($urandom_range(2)));
		wait_for_idle();
	endtask

	// Random tiles under a series of threshold settings: reset values, the
	// extremes, out of order, and random ones. Tile sizes are square numbers,
	// mostly small. Idling varies from none at all to heavy.
	task automatic test_random_tiles();
		chan_t lo_list [NumSettings];
		chan_t hi_list [NumSettings];
		int    seg_pixels;
		int    size;
		lo_list = '{8'd85,  8'd0,   8'd255, 8'd0, 8'd255, 8'd200, 8'd0, 8'd0};
		hi_list = '{8'd170, 8'd255, 8'd0,   8'd0, 8'd255, 8'd100, 8'd0, 8'd0};
		for (int seg = 0; seg < NumSettings; seg++) begin
			if (seg == 6) begin
				lo_list[seg] = chan_t'($urandom_range(200, 1));
				hi_list[seg] = chan_t'($urandom_range(255, int'(lo_list[seg]) + 1));
			end else if (seg == 7) begin
				lo_list[seg] = chan_t'($urandom_range(255));
				hi_list[seg] = chan_t'($urandom_range(255));
			end
			set_thresholds(lo_list[seg], hi_list[seg]);
			idle_pct  = (seg == 0) ? 0 : $urandom_range(50, 10);
			stall_pct = (seg == 0) ? 0 : $urandom_range(50, 10);
			seg_pixels = 0;
			while (seg_pixels < RandomPixelsPerSetting) begin
				case ($urandom_range(19))
					0, 1, 2, 3, 4, 5: size = 1;
					6, 7, 8, 9, 10:   size = 4;
					11, 12, 13, 14:   size = 9;
					15, 16:           size = 16;
					17:               size = 25;
					18:               size = 36;
					default:          size = 64;
				endcase
				send_tile(size, level_t'($urandom_range(2)),
					level_t'($urandom_range(2)), level_t'($urandom_range(2)));
				seg_pixels += size;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver, checker and watchdog
	// ------------------------------------------------------------------

	// Drives tile_ready: a forced hold-off when one is requested, otherwise
	// random stalls of random length.
	always @(negedge clk) begin
		if (hold_len > 0) begin
			hold_left = hold_len;
			hold_len  = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			tile_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			tile_ready <= 1'b0;
		end else if ($urandom_range(99) < stall_pct) begin
			stall_left = gap_length() - 1;
			tile_ready <= 1'b0;
		end else begin
			tile_ready <= 1'b1;
		end
	end

	// Every color transaction is matched against the oldest predicted color.
	always @(posedge clk) begin
		if (arst_n && tile_valid && tile_ready) begin
			if (pending_colors.size() == 0) begin
				$error("tile color %0d/%0d/%0d arrived with none expected",
					out_red, out_green, out_blue);
				fail_count++;
			end else begin
				head_color = pending_colors.pop_front();
				tiles_checked++;
				if (out_red !== head_color.red) begin
					$error("out_red mismatch: expected %0d, actual %0d",
						head_color.red, out_red);
					fail_count++;
				end
				if (out_green !== head_color.green) begin
					$error("out_green mismatch: expected %0d, actual %0d",
						head_color.green, out_green);
					fail_count++;
				end
				if (out_blue !== head_color.blue) begin
					$error("out_blue mismatch: expected %0d, actual %0d",
						head_color.blue, out_blue);
					fail_count++;
				end
			end
		end
	end

	// Ends the run if no transaction of any kind completes for too long.
	always @(posedge clk) begin
		if (!arst_n || (pix_valid && pix_ready) || (tile_valid && tile_ready) ||
				(psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= StallLimit) begin
			$display("Timeout: no transaction for %0d cycles", StallLimit);
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		pix_valid    = 1'b0;
		red          = '0;
		green        = '0;
		blue         = '0;
		last_in_tile = 1'b0;
		tile_ready   = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		low_thr      = LowThresholdReset;
		high_thr     = HighThresholdReset;
		for (int ch = 0; ch < 3; ch++)
			for (int lv = 0; lv < NumLevels; lv++)
				tally[ch][lv] = '0;
		idle_pct         = 30;
		stall_pct        = 30;
		hold_len         = 0;
		hold_left        = 0;
		stall_left       = 0;
		fail_count       = 0;
		quiet_cycles     = 0;
		pixels_sent      = 0;
		tiles_sent       = 0;
		tiles_checked    = 0;
		threshold_writes = 0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_reset();
		test_level_boundaries();
		test_tie_breaking();
		test_inverted_thresholds();
		test_output_backpressure();
		test_random_tiles();
		wait_for_idle();

		$display("Sent %0d pixels in %0d tiles and checked %0d tile colors,",
			pixels_sent, tiles_sent, tiles_checked);
		$display("with %0d threshold writes, inverted thresholds and a long output stall.",
			threshold_writes);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d check(s) failed", fail_count);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/tmcq_pkg.sv
design/tmcq_lane.sv
design/tmcq_merge.sv
design/tile_majority_color_quantizer_top.sv
dv/tile_majority_color_quantizer_top_tb.sv
